>>> design/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/i2cadc_pkg.sv
// shared types and codes of the i2c converter transaction master
package i2cadc_pkg;

  localparam int PHASE_W = 5;
  localparam int OP_W    = 4;
  localparam int FUNC_W  = 3;
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 7;
  localparam int REG_W   = 16;
  localparam int PADDR_W = 5;

  // bus phases
  localparam logic [PHASE_W-1:0] PH_IDLE     = 5'd0;
  localparam logic [PHASE_W-1:0] PH_ST_FREE  = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ST_HOLD  = 5'd2;
  localparam logic [PHASE_W-1:0] PH_SB_HOLD  = 5'd3;
  localparam logic [PHASE_W-1:0] PH_SB_SETUP = 5'd4;
  localparam logic [PHASE_W-1:0] PH_SB_LOW   = 5'd5;
  localparam logic [PHASE_W-1:0] PH_SB_LOWF  = 5'd6;
  localparam logic [PHASE_W-1:0] PH_SB_HIGH  = 5'd7;
  localparam logic [PHASE_W-1:0] PH_RB_LOW   = 5'd8;
  localparam logic [PHASE_W-1:0] PH_RB_SETUP = 5'd9;
  localparam logic [PHASE_W-1:0] PH_RB_HIGH  = 5'd10;
  localparam logic [PHASE_W-1:0] PH_SP_SETUP = 5'd11;
  localparam logic [PHASE_W-1:0] PH_SP_LOW   = 5'd12;
  localparam logic [PHASE_W-1:0] PH_SP_SUSTO = 5'd13;

  // transaction steps
  localparam logic [OP_W-1:0] OP_END     = 4'd0;
  localparam logic [OP_W-1:0] OP_START   = 4'd1;
  localparam logic [OP_W-1:0] OP_S_GC    = 4'd2;
  localparam logic [OP_W-1:0] OP_S_RST   = 4'd3;
  localparam logic [OP_W-1:0] OP_S_AW    = 4'd4;
  localparam logic [OP_W-1:0] OP_S_AR    = 4'd5;
  localparam logic [OP_W-1:0] OP_S_PTR   = 4'd6;
  localparam logic [OP_W-1:0] OP_S_ONE   = 4'd7;
  localparam logic [OP_W-1:0] OP_S_HI    = 4'd8;
  localparam logic [OP_W-1:0] OP_S_LO    = 4'd9;
  localparam logic [OP_W-1:0] OP_R_HI    = 4'd10;
  localparam logic [OP_W-1:0] OP_R_LO    = 4'd11;
  localparam logic [OP_W-1:0] OP_RESTART = 4'd12;
  localparam logic [OP_W-1:0] OP_STOP    = 4'd13;

  // command codes on the input beat
  localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_GC_RESET  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RD_CFG    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RD_SAMPLE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_WR_CFG    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_GC        = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RD_CFG    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RD_SAMPLE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_WR_CFG    = 2'd3;

  // register indexes
  localparam logic [2:0] REG_DEV_ADDR   = 3'd0;
  localparam logic [2:0] REG_BUS_FREE   = 3'd1;
  localparam logic [2:0] REG_START_HOLD = 3'd2;
  localparam logic [2:0] REG_DATA_HOLD  = 3'd3;
  localparam logic [2:0] REG_DATA_SETUP = 3'd4;
  localparam logic [2:0] REG_CLK_LOW    = 3'd5;
  localparam logic [2:0] REG_CLK_HIGH   = 3'd6;
  localparam logic [2:0] REG_STOP_SETUP = 3'd7;

  localparam logic [ADDR_W-1:0] RST_DEV_ADDR   = 7'd72;
  localparam logic [REG_W-1:0]  RST_BUS_FREE   = 16'd10;
  localparam logic [REG_W-1:0]  RST_START_HOLD = 16'd10;
  localparam logic [REG_W-1:0]  RST_DATA_HOLD  = 16'd1;
  localparam logic [REG_W-1:0]  RST_DATA_SETUP = 16'd5;
  localparam logic [REG_W-1:0]  RST_CLK_LOW    = 16'd10;
  localparam logic [REG_W-1:0]  RST_CLK_HIGH   = 16'd10;
  localparam logic [REG_W-1:0]  RST_STOP_SETUP = 16'd10;

  // bytes sent on the bus
  localparam logic [7:0] GC_BYTE     = 8'h00;
  localparam logic [7:0] RST_BYTE    = 8'h06;
  localparam logic [7:0] PTR_SAMPLE  = 8'h00;
  localparam logic [7:0] PTR_CONFIG  = 8'h01;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [3:0]         bit_idx;
    logic [2:0]         byte_idx;
    logic [7:0]         shift;
    logic               sda;
    logic               scl;
    logic [15:0]        rdata;
    logic [3:0]         ack;
    logic [KIND_W-1:0]  kind;
    logic [15:0]        wval;
    logic               done;
  } seq_state_t;

  typedef struct packed {
    logic        scl_release;
    logic        sda_release;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_word;
    logic [3:0]  ack_bits;
  } result_t;

  typedef struct packed {
    logic loop;
    logic emit;
    logic idle;
  } seq_stat_t;

endpackage

>>> design/i2cadc_cfg.sv
// register file of the configuration port with clamped phase targets
module i2cadc_cfg #(
  parameter int TW = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2cadc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic [i2cadc_pkg::ADDR_W-1:0]  dev_addr,
  output logic [TW-1:0]                  t_free,
  output logic [TW-1:0]                  t_start,
  output logic [TW-1:0]                  t_dhold,
  output logic [TW-1:0]                  t_setup,
  output logic [TW-1:0]                  t_low,
  output logic [TW-1:0]                  t_high,
  output logic [TW-1:0]                  t_stop,
  output logic [TW-1:0]                  t_low_hs,
  output logic [TW-1:0]                  t_high_s,
  output logic [TW-1:0]                  t_low_s
);
  import i2cadc_pkg::*;

  localparam int CW = (TW > 17) ? TW : 17;

  logic [ADDR_W-1:0] dev_r, dev_nxt;
  logic [REG_W-1:0]  free_r, free_nxt, start_r, start_nxt, dhold_r, dhold_nxt;
  logic [REG_W-1:0]  setup_r, setup_nxt, low_r, low_nxt, high_r, high_nxt;
  logic [REG_W-1:0]  stop_r, stop_nxt;
  logic [TW-1:0]     free_t_r, start_t_r, dhold_t_r, setup_t_r, low_t_r, high_t_r;
  logic [TW-1:0]     stop_t_r, low_hs_t_r, high_s_t_r, low_s_t_r;
  logic              wr;
  logic [2:0]        idx;

  // saturate to the tick counter range
  function automatic logic [TW-1:0] lim(input logic [16:0] v);
    logic [CW-1:0] ve;
    logic [CW-1:0] mx;
    ve = CW'(v);
    mx = CW'({TW{1'b1}});
    lim = (ve > mx) ? mx[TW-1:0] : ve[TW-1:0];
  endfunction

  // a minus b, floored at zero
  function automatic logic [16:0] sub0(input logic [15:0] a, input logic [16:0] b);
    logic [16:0] ae;
    ae = {1'b0, a};
    sub0 = (ae > b) ? (ae - b) : 17'd0;
  endfunction

  assign wr  = psel & penable & pwrite;
  assign idx = paddr[4:2];

  always_comb begin
    dev_nxt   = dev_r;
    free_nxt  = free_r;
    start_nxt = start_r;
    dhold_nxt = dhold_r;
    setup_nxt = setup_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    stop_nxt  = stop_r;
    if (wr) begin
      unique case (idx)
        REG_DEV_ADDR:   dev_nxt   = pwdata[ADDR_W-1:0];
        REG_BUS_FREE:   free_nxt  = pwdata[REG_W-1:0];
        REG_START_HOLD: start_nxt = pwdata[REG_W-1:0];
        REG_DATA_HOLD:  dhold_nxt = pwdata[REG_W-1:0];
        REG_DATA_SETUP: setup_nxt = pwdata[REG_W-1:0];
        REG_CLK_LOW:    low_nxt   = pwdata[REG_W-1:0];
        REG_CLK_HIGH:   high_nxt  = pwdata[REG_W-1:0];
        REG_STOP_SETUP: stop_nxt  = pwdata[REG_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r   <= RST_DEV_ADDR;
      free_r  <= RST_BUS_FREE;
      start_r <= RST_START_HOLD;
      dhold_r <= RST_DATA_HOLD;
      setup_r <= RST_DATA_SETUP;
      low_r   <= RST_CLK_LOW;
      high_r  <= RST_CLK_HIGH;
      stop_r  <= RST_STOP_SETUP;
    end else begin
      dev_r   <= dev_nxt;
      free_r  <= free_nxt;
      start_r <= start_nxt;
      dhold_r <= dhold_nxt;
      setup_r <= setup_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      stop_r  <= stop_nxt;
    end
  end

  // targets follow the next register values so they line up with the registers
  always_ff @(posedge clk) begin
    free_t_r   <= lim({1'b0, free_nxt});
    start_t_r  <= lim({1'b0, start_nxt});
    dhold_t_r  <= lim({1'b0, dhold_nxt});
    setup_t_r  <= lim({1'b0, setup_nxt});
    low_t_r    <= lim({1'b0, low_nxt});
    high_t_r   <= lim({1'b0, high_nxt});
    stop_t_r   <= lim({1'b0, stop_nxt});
    low_hs_t_r <= lim(sub0(low_nxt, {1'b0, dhold_nxt} + {1'b0, setup_nxt}));
    high_s_t_r <= lim(sub0(high_nxt, {1'b0, setup_nxt}));
    low_s_t_r  <= lim(sub0(low_nxt, {1'b0, setup_nxt}));
  end

  always_comb begin
    unique case (idx)
      REG_DEV_ADDR:   prdata = 32'(dev_r);
      REG_BUS_FREE:   prdata = 32'(free_r);
      REG_START_HOLD: prdata = 32'(start_r);
      REG_DATA_HOLD:  prdata = 32'(dhold_r);
      REG_DATA_SETUP: prdata = 32'(setup_r);
      REG_CLK_LOW:    prdata = 32'(low_r);
      REG_CLK_HIGH:   prdata = 32'(high_r);
      REG_STOP_SETUP: prdata = 32'(stop_r);
    endcase
  end

  assign dev_addr = dev_r;
  assign t_free   = free_t_r;
  assign t_start  = start_t_r;
  assign t_dhold  = dhold_t_r;
  assign t_setup  = setup_t_r;
  assign t_low    = low_t_r;
  assign t_high   = high_t_r;
  assign t_stop   = stop_t_r;
  assign t_low_hs = low_hs_t_r;
  assign t_high_s = high_s_t_r;
  assign t_low_s  = low_s_t_r;

endmodule

>>> design/i2cadc_core.sv
// bus sequencer: tick counter, phase machine and one bus action per cycle
module i2cadc_core #(
  parameter int TW = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [i2cadc_pkg::FUNC_W-1:0] func,
  input  logic [15:0]                   write_word,
  input  logic                          sda_in,
  output logic                          in_ready,
  input  logic                          out_ok,
  input  logic [i2cadc_pkg::ADDR_W-1:0] dev_addr,
  input  logic [TW-1:0]                 t_free,
  input  logic [TW-1:0]                 t_start,
  input  logic [TW-1:0]                 t_dhold,
  input  logic [TW-1:0]                 t_setup,
  input  logic [TW-1:0]                 t_low,
  input  logic [TW-1:0]                 t_high,
  input  logic [TW-1:0]                 t_stop,
  input  logic [TW-1:0]                 t_low_hs,
  input  logic [TW-1:0]                 t_high_s,
  input  logic [TW-1:0]                 t_low_s,
  output i2cadc_pkg::result_t           res,
  output i2cadc_pkg::seq_stat_t         stat
);
  import i2cadc_pkg::*;

  seq_state_t  st_r, st_nxt;
  logic [TW-1:0] tick_r, tick_nxt;
  logic        pending_r, pending_nxt;
  logic        sample_r, sample_nxt;
  logic [TW-1:0] tgt;
  logic        cond, loop_now, emit, accept;

  function automatic logic [OP_W-1:0] cur_op(input logic [KIND_W-1:0] k,
                                             input logic [2:0] b);
    logic [OP_W-1:0] op;
    op = OP_END;
    unique case (k)
      KIND_GC: begin
        unique case (b)
          3'd0:    op = OP_START;
          3'd1:    op = OP_S_GC;
          3'd2:    op = OP_S_RST;
          3'd3:    op = OP_STOP;
          default: op = OP_END;
        endcase
      end
      KIND_RD_CFG, KIND_RD_SAMPLE: begin
        unique case (b)
          3'd0: op = OP_START;
          3'd1: op = OP_S_AW;
          3'd2: op = OP_S_PTR;
          3'd3: op = OP_RESTART;
          3'd4: op = OP_S_AR;
          3'd5: op = OP_R_HI;
          3'd6: op = OP_R_LO;
          3'd7: op = OP_STOP;
        endcase
      end
      KIND_WR_CFG: begin
        unique case (b)
          3'd0:    op = OP_START;
          3'd1:    op = OP_S_AW;
          3'd2:    op = OP_S_ONE;
          3'd3:    op = OP_S_HI;
          3'd4:    op = OP_S_LO;
          3'd5:    op = OP_STOP;
          default: op = OP_END;
        endcase
      end
    endcase
    return op;
  endfunction

  // ack_bits position of each sent byte
  function automatic logic [1:0] ack_slot(input logic [KIND_W-1:0] k, input logic [2:0] b);
    logic [1:0] s;
    s = 2'd0;
    if (b == 3'd2) s = 2'd1;
    else if (b == 3'd4 && k != KIND_GC) s = (k == KIND_WR_CFG) ? 2'd3 : 2'd2;
    else if (b == 3'd3 && k == KIND_WR_CFG) s = 2'd2;
    return s;
  endfunction

  function automatic logic is_send(input logic [OP_W-1:0] op);
    return (op >= OP_S_GC) && (op <= OP_S_LO);
  endfunction

  function automatic logic is_recv(input logic [OP_W-1:0] op);
    return (op == OP_R_HI) || (op == OP_R_LO);
  endfunction

  function automatic logic [7:0] send_value(input logic [OP_W-1:0] op,
                                            input seq_state_t s,
                                            input logic [ADDR_W-1:0] a);
    logic [7:0] v;
    unique case (op)
      OP_S_GC:  v = GC_BYTE;
      OP_S_RST: v = RST_BYTE;
      OP_S_AW:  v = {a, 1'b0};
      OP_S_AR:  v = {a, 1'b1};
      OP_S_PTR: v = (s.kind == KIND_RD_CFG) ? PTR_CONFIG : PTR_SAMPLE;
      OP_S_ONE: v = PTR_CONFIG;
      OP_S_HI:  v = s.wval[15:8];
      OP_S_LO:  v = s.wval[7:0];
      default:  v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic next_level(input seq_state_t s);
    return is_send(cur_op(s.kind, s.byte_idx)) && (s.bit_idx < 4'd8) && s.shift[7];
  endfunction

  function automatic seq_state_t begin_bit(input seq_state_t s);
    seq_state_t r;
    logic [OP_W-1:0] op;
    logic send_now;
    r = s;
    op = cur_op(s.kind, s.byte_idx);
    send_now = is_send(op) ? (s.bit_idx < 4'd8) : (s.bit_idx >= 4'd8);
    if (send_now) begin
      r.phase = (next_level(s) != s.sda) ? PH_SB_HOLD : PH_SB_LOWF;
    end else begin
      r.sda   = 1'b1;
      r.phase = PH_RB_LOW;
    end
    return r;
  endfunction

  function automatic seq_state_t begin_item(input seq_state_t s,
                                            input logic [ADDR_W-1:0] a);
    seq_state_t r;
    logic [OP_W-1:0] op;
    r = s;
    op = cur_op(s.kind, s.byte_idx);
    r.bit_idx = 4'd0;
    if (op == OP_START) begin
      r.phase = PH_ST_FREE;
    end else if (is_send(op)) begin
      r.shift = send_value(op, s, a);
      r = begin_bit(r);
    end else if (is_recv(op)) begin
      r.shift = 8'd0;
      r = begin_bit(r);
    end else if (op == OP_STOP || op == OP_RESTART) begin
      r.sda   = 1'b0;
      r.phase = PH_SP_SETUP;
    end else begin
      r.phase = PH_IDLE;
      r.done  = 1'b1;
    end
    return r;
  endfunction

  function automatic seq_state_t bit_done(input seq_state_t s,
                                          input logic [ADDR_W-1:0] a);
    seq_state_t r;
    logic [OP_W-1:0] op;
    r = s;
    op = cur_op(s.kind, s.byte_idx);
    if (is_send(op) && s.bit_idx < 4'd8) r.shift = {s.shift[6:0], 1'b0};
    r.bit_idx = s.bit_idx + 4'd1;
    if (r.bit_idx >= 4'd9) begin
      if (op == OP_R_HI) r.rdata[15:8] = r.shift;
      if (op == OP_R_LO) r.rdata[7:0] = r.shift;
      r.byte_idx = s.byte_idx + 3'd1;
      r = begin_item(r, a);
    end else begin
      r = begin_bit(r);
    end
    return r;
  endfunction

  // one bus action; every action restarts the tick count
  function automatic seq_state_t act(input seq_state_t s,
                                     input logic [ADDR_W-1:0] a,
                                     input logic smp);
    seq_state_t r;
    logic [OP_W-1:0] op;
    r = s;
    op = cur_op(s.kind, s.byte_idx);
    unique case (s.phase)
      PH_ST_FREE: begin
        r.sda   = 1'b0;
        r.phase = PH_ST_HOLD;
      end
      PH_ST_HOLD: begin
        r.scl      = 1'b0;
        r.byte_idx = s.byte_idx + 3'd1;
        r = begin_item(r, a);
      end
      PH_SB_HOLD: begin
        r.sda   = next_level(s);
        r.phase = PH_SB_SETUP;
      end
      PH_SB_SETUP: r.phase = PH_SB_LOW;
      PH_SB_LOW, PH_SB_LOWF: begin
        r.scl   = 1'b1;
        r.phase = PH_SB_HIGH;
      end
      PH_SB_HIGH, PH_RB_HIGH: begin
        r.scl = 1'b0;
        r = bit_done(r, a);
      end
      PH_RB_LOW: begin
        r.scl   = 1'b1;
        r.phase = PH_RB_SETUP;
      end
      PH_RB_SETUP: begin
        if (is_send(op)) r.ack = s.ack | (4'(smp) << ack_slot(s.kind, s.byte_idx));
        else r.shift = {s.shift[6:0], smp};
        r.phase = PH_RB_HIGH;
      end
      PH_SP_SETUP: r.phase = PH_SP_LOW;
      PH_SP_LOW: begin
        r.scl   = 1'b1;
        r.phase = PH_SP_SUSTO;
      end
      PH_SP_SUSTO: begin
        r.sda = 1'b1;
        if (op == OP_RESTART) begin
          r.phase = PH_ST_FREE;
        end else begin
          r.phase = PH_IDLE;
          r.done  = 1'b1;
        end
      end
      default: begin
        r.phase = PH_IDLE;
        r.done  = 1'b1;
      end
    endcase
    return r;
  endfunction

  always_comb begin
    unique case (st_r.phase)
      PH_ST_FREE:  tgt = t_free;
      PH_ST_HOLD:  tgt = t_start;
      PH_SB_HOLD:  tgt = t_dhold;
      PH_SB_SETUP: tgt = t_setup;
      PH_SB_LOW:   tgt = t_low_hs;
      PH_SB_LOWF:  tgt = t_low;
      PH_SB_HIGH:  tgt = t_high;
      PH_RB_LOW:   tgt = t_low;
      PH_RB_SETUP: tgt = t_setup;
      PH_RB_HIGH:  tgt = t_high_s;
      PH_SP_SETUP: tgt = t_setup;
      PH_SP_LOW:   tgt = t_low_s;
      PH_SP_SUSTO: tgt = t_stop;
      default:     tgt = '0;
    endcase
  end

  // a due action holds the beat; otherwise the tick result goes out
  assign cond     = (st_r.phase != PH_IDLE) && (tick_r >= tgt);
  assign loop_now = pending_r && cond;
  assign emit     = pending_r && !cond && out_ok;
  assign in_ready = !pending_r || emit;
  assign accept   = in_valid && in_ready;

  always_comb begin
    st_nxt      = st_r;
    tick_nxt    = tick_r;
    pending_nxt = pending_r;
    sample_nxt  = sample_r;
    if (loop_now) begin
      st_nxt   = act(st_r, dev_addr, sample_r);
      tick_nxt = '0;
    end else if (accept) begin
      pending_nxt = 1'b1;
      sample_nxt  = sda_in;
      st_nxt.done = 1'b0;
      if (st_r.phase != PH_IDLE) begin
        if (!(&tick_r)) tick_nxt = tick_r + TW'(1);
      end else if (func == FUNC_GC_RESET || func == FUNC_RD_CFG ||
                   func == FUNC_RD_SAMPLE || func == FUNC_WR_CFG) begin
        st_nxt.kind     = KIND_W'(func - FUNC_GC_RESET);
        st_nxt.wval     = write_word;
        st_nxt.ack      = 4'd0;
        st_nxt.byte_idx = 3'd0;
        st_nxt.bit_idx  = 4'd0;
        st_nxt.phase    = PH_ST_FREE;
        tick_nxt        = '0;
      end
    end else if (emit) begin
      pending_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      st_r.sda    <= 1'b1;
      st_r.scl    <= 1'b1;
      tick_r      <= '0;
      pending_r   <= 1'b0;
      sample_r    <= 1'b1;
    end else begin
      st_r      <= st_nxt;
      tick_r    <= tick_nxt;
      pending_r <= pending_nxt;
      sample_r  <= sample_nxt;
    end
  end

  assign res.scl_release = st_r.scl;
  assign res.sda_release = st_r.sda;
  assign res.busy_res    = st_r.phase != PH_IDLE;
  assign res.done_res    = st_r.done;
  assign res.read_word   = st_r.rdata;
  assign res.ack_bits    = st_r.ack;

  assign stat.loop = loop_now;
  assign stat.emit = emit;
  assign stat.idle = st_r.phase == PH_IDLE;

endmodule

>>> design/i2cadc_out.sv
// result register of the output stream
module i2cadc_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  i2cadc_pkg::result_t res,
  output logic                can_load,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata
);
  import i2cadc_pkg::*;

  logic        valid_r, valid_nxt;
  logic [23:0] data_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {res.ack_bits, res.read_word, res.done_res, res.busy_res,
                 res.sda_release, res.scl_release};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

>>> design/i2c_adc_transaction_master.sv
// timing: an accepted tick beat is held in the core while its due bus actions run one by one
// (delays of zero chain actions); then its result is loaded into the output register
// throughput: one tick beat per cycle; the single-action sequencer and output stalls hold it
// reset: synchronous active-low rst_n; bus released, sequencer idle, registers at defaults
module i2c_adc_transaction_master #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // write_word[15:0], sda_in[16], zero pad
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_release[0], sda_release[1], busy_res[2], done_res[3], read_word[19:4], ack_bits[23:20]
  output logic [23:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import i2cadc_pkg::*;

`include "assert_macros.svh"

  localparam int TW = TIMER_WIDTH;

  logic [ADDR_W-1:0] dev_addr;
  logic [TW-1:0]     t_free, t_start, t_dhold, t_setup, t_low, t_high, t_stop;
  logic [TW-1:0]     t_low_hs, t_high_s, t_low_s;
  result_t           res;
  seq_stat_t         stat;
  logic              out_ok;

  assign cfg_pready = 1'b1;

  i2cadc_cfg #(.TW(TW)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .dev_addr (dev_addr),
    .t_free   (t_free),
    .t_start  (t_start),
    .t_dhold  (t_dhold),
    .t_setup  (t_setup),
    .t_low    (t_low),
    .t_high   (t_high),
    .t_stop   (t_stop),
    .t_low_hs (t_low_hs),
    .t_high_s (t_high_s),
    .t_low_s  (t_low_s)
  );

  i2cadc_core #(.TW(TW)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .func       (in_tuser),
    .write_word (in_tdata[15:0]),
    .sda_in     (in_tdata[16]),
    .in_ready   (in_tready),
    .out_ok     (out_ok),
    .dev_addr   (dev_addr),
    .t_free     (t_free),
    .t_start    (t_start),
    .t_dhold    (t_dhold),
    .t_setup    (t_setup),
    .t_low      (t_low),
    .t_high     (t_high),
    .t_stop     (t_stop),
    .t_low_hs   (t_low_hs),
    .t_high_s   (t_high_s),
    .t_low_s    (t_low_s),
    .res        (res),
    .stat       (stat)
  );

  i2cadc_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (stat.emit),
    .res        (res),
    .can_load   (out_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // no new tick is taken while the current tick still has a bus action due
  `ASSERT_IMP(a_hold_in_loop, clk, rst_n, stat.loop, !in_tready, "beat taken during action")
  // a finished tick lands in the result register
  `ASSERT_NXT(a_emit_valid, clk, rst_n, stat.emit, out_tvalid, "result not registered")
  // an accepted command leaves the idle phase
  `ASSERT_NXT(a_cmd_starts, clk, rst_n,
    in_tvalid && in_tready && stat.idle && (in_tuser == FUNC_GC_RESET ||
    in_tuser == FUNC_RD_CFG || in_tuser == FUNC_RD_SAMPLE || in_tuser == FUNC_WR_CFG),
    !stat.idle, "command did not start")
  // the finishing tick reports the bus free
  `ASSERT_IMP(a_done_idle, clk, rst_n, out_tvalid && out_tdata[3], !out_tdata[2],
    "done while busy")

endmodule

>>> sim/tb_i2c_adc_transaction_master.sv
// testbench for the i2c converter transaction master: tick stream, bus timing and read-back checks
`timescale 1ns / 100ps

module tb_i2c_adc_transaction_master;
  import i2cadc_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 48;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 280;
  localparam int TAIL_ITEMS      = 60;
  localparam int unsigned TICK_SAT = 65535;

  // codes the block treats as no command
  localparam logic [FUNC_W-1:0] FUNC_NONE_A = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_NONE_B = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_NONE_C = 3'd7;

  // register sets for the directed rows
  localparam logic [1:0] PROF_KEEP = 2'd0;
  localparam logic [1:0] PROF_FAST = 2'd1;
  localparam logic [1:0] PROF_WIDE = 2'd2;
  localparam logic [1:0] PROF_MAX  = 2'd3;

  // what follows a directed row until the bus goes idle
  localparam logic [1:0] TAIL_NONE = 2'd0;
  localparam logic [1:0] TAIL_HOLD = 2'd1;
  localparam logic [1:0] TAIL_RAND = 2'd2;

  localparam result_t IDLE_RES = '{1'b1, 1'b1, 1'b0, 1'b0, 16'h0000, 4'h0};
  localparam result_t BUSY_RES = '{1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 4'h0};

  typedef struct packed {
    logic [ADDR_W-1:0] dev;
    logic [REG_W-1:0]  free;
    logic [REG_W-1:0]  sthold;
    logic [REG_W-1:0]  dhold;
    logic [REG_W-1:0]  dsetup;
    logic [REG_W-1:0]  low;
    logic [REG_W-1:0]  high;
    logic [REG_W-1:0]  stop;
  } bus_timing_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [15:0]       word;
    logic              sda;
    logic [1:0]        prof;
    logic              typed;
    result_t           want;
    logic [1:0]        tail;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // write_word[15:0], sda_in[16], zero pad
  logic [2:0]  in_tuser = '0;   // func[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // scl_release[0], sda_release[1], busy_res[2], done_res[3], read_word[19:4], ack_bits[23:20]
  logic [23:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  i2c_adc_transaction_master dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bus sequencer mirror: registers and state
  logic [ADDR_W-1:0]  reg_dev;
  logic [REG_W-1:0]   reg_free, reg_sthold, reg_dhold, reg_dsetup, reg_low, reg_high, reg_stop;
  logic [PHASE_W-1:0] m_phase;
  int unsigned        m_ticks;
  logic [3:0]         m_bit;
  logic [2:0]         m_byte;
  logic [7:0]         m_shift;
  logic               m_sda, m_scl;
  logic [15:0]        m_rword;
  logic [3:0]         m_ack;
  logic [KIND_W-1:0]  m_kind;
  logic [15:0]        m_wval;
  logic               m_done, m_sample;

  result_t  pending_res [$];
  dir_row_t dir_rows [$];
  int n_fail, beats_sent, results_seen, n_settings, quiet_cycles;
  int done_by_kind [4];
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  int stall_left;

  function automatic logic [OP_W-1:0] plan_step();
    case (m_kind)
      KIND_GC:
        case (m_byte)
          3'd0: return OP_START;
          3'd1: return OP_S_GC;
          3'd2: return OP_S_RST;
          3'd3: return OP_STOP;
          default: return OP_END;
        endcase
      KIND_WR_CFG:
        case (m_byte)
          3'd0: return OP_START;
          3'd1: return OP_S_AW;
          3'd2: return OP_S_ONE;
          3'd3: return OP_S_HI;
          3'd4: return OP_S_LO;
          3'd5: return OP_STOP;
          default: return OP_END;
        endcase
      default:
        case (m_byte)
          3'd0: return OP_START;
          3'd1: return OP_S_AW;
          3'd2: return OP_S_PTR;
          3'd3: return OP_RESTART;
          3'd4: return OP_S_AR;
          3'd5: return OP_R_HI;
          3'd6: return OP_R_LO;
          default: return OP_STOP;
        endcase
    endcase
  endfunction

  function automatic logic is_send(logic [OP_W-1:0] op);
    return op >= OP_S_GC && op <= OP_S_LO;
  endfunction

  function automatic logic is_recv(logic [OP_W-1:0] op);
    return op == OP_R_HI || op == OP_R_LO;
  endfunction

  function automatic logic [7:0] byte_to_send(logic [OP_W-1:0] op);
    case (op)
      OP_S_GC:  return GC_BYTE;
      OP_S_RST: return RST_BYTE;
      OP_S_AW:  return {reg_dev, 1'b0};
      OP_S_AR:  return {reg_dev, 1'b1};
      OP_S_PTR: return (m_kind == KIND_RD_CFG) ? PTR_CONFIG : PTR_SAMPLE;
      OP_S_ONE: return PTR_CONFIG;
      OP_S_HI:  return m_wval[15:8];
      OP_S_LO:  return m_wval[7:0];
      default:  return 8'h00;
    endcase
  endfunction

  // position of a sent byte in ack_bits
  function automatic int unsigned ack_slot(logic [OP_W-1:0] op);
    case (op)
      OP_S_RST, OP_S_PTR, OP_S_ONE: return 1;
      OP_S_AR, OP_S_HI:             return 2;
      OP_S_LO:                      return 3;
      default:                      return 0;
    endcase
  endfunction

  function automatic int unsigned floor_sub(int unsigned a, int unsigned b);
    return (a > b) ? a - b : 0;
  endfunction

  function automatic int unsigned wait_ticks();
    case (m_phase)
      PH_ST_FREE:  return reg_free;
      PH_ST_HOLD:  return reg_sthold;
      PH_SB_HOLD:  return reg_dhold;
      PH_SB_SETUP: return reg_dsetup;
      PH_SB_LOW:   return floor_sub(reg_low, int'(reg_dhold) + int'(reg_dsetup));
      PH_SB_LOWF:  return reg_low;
      PH_SB_HIGH:  return reg_high;
      PH_RB_LOW:   return reg_low;
      PH_RB_SETUP: return reg_dsetup;
      PH_RB_HIGH:  return floor_sub(reg_high, reg_dsetup);
      PH_SP_SETUP: return reg_dsetup;
      PH_SP_LOW:   return floor_sub(reg_low, reg_dsetup);
      PH_SP_SUSTO: return reg_stop;
      default:     return 0;
    endcase
  endfunction

  function automatic logic next_sda();
    if (is_send(plan_step()) && m_bit < 4'd8) return m_shift[7];
    return 1'b0;
  endfunction

  function automatic void enter(logic [PHASE_W-1:0] p);
    m_phase = p;
    m_ticks = 0;
  endfunction

  function automatic void wrap_up();
    enter(PH_IDLE);
    m_done = 1'b1;
    done_by_kind[m_kind]++;
  endfunction

  function automatic void start_bit();
    logic [OP_W-1:0] op;
    logic send_now;
    op = plan_step();
    send_now = is_send(op) ? (m_bit < 4'd8) : (m_bit >= 4'd8);
    if (send_now) begin
      enter(next_sda() != m_sda ? PH_SB_HOLD : PH_SB_LOWF);
    end else begin
      m_sda = 1'b1;
      enter(PH_RB_LOW);
    end
  endfunction

  function automatic void start_item();
    logic [OP_W-1:0] op;
    op = plan_step();
    m_bit = 4'd0;
    if (op == OP_START) begin
      enter(PH_ST_FREE);
    end else if (is_send(op)) begin
      m_shift = byte_to_send(op);
      start_bit();
    end else if (is_recv(op)) begin
      m_shift = 8'h00;
      start_bit();
    end else if (op == OP_STOP || op == OP_RESTART) begin
      m_sda = 1'b0;
      enter(PH_SP_SETUP);
    end else begin
      wrap_up();
    end
  endfunction

  function automatic void end_bit();
    logic [OP_W-1:0] op;
    op = plan_step();
    if (is_send(op) && m_bit < 4'd8) m_shift = m_shift << 1;
    m_bit = m_bit + 4'd1;
    if (m_bit >= 4'd9) begin
      if (op == OP_R_HI) m_rword[15:8] = m_shift;
      if (op == OP_R_LO) m_rword[7:0] = m_shift;
      m_byte = m_byte + 3'd1;
      start_item();
    end else begin
      start_bit();
    end
  endfunction

  function automatic void advance();
    logic [OP_W-1:0] op;
    op = plan_step();
    case (m_phase)
      PH_ST_FREE: begin
        m_sda = 1'b0;
        enter(PH_ST_HOLD);
      end
      PH_ST_HOLD: begin
        m_scl = 1'b0;
        m_byte = m_byte + 3'd1;
        start_item();
      end
      PH_SB_HOLD: begin
        m_sda = next_sda();
        enter(PH_SB_SETUP);
      end
      PH_SB_SETUP: enter(PH_SB_LOW);
      PH_SB_LOW, PH_SB_LOWF: begin
        m_scl = 1'b1;
        enter(PH_SB_HIGH);
      end
      PH_SB_HIGH, PH_RB_HIGH: begin
        m_scl = 1'b0;
        end_bit();
      end
      PH_RB_LOW: begin
        m_scl = 1'b1;
        enter(PH_RB_SETUP);
      end
      PH_RB_SETUP: begin
        // ack of a sent byte, or one more bit of a received byte
        if (is_send(op)) m_ack = m_ack | (4'(m_sample) << ack_slot(op));
        else m_shift = {m_shift[6:0], m_sample};
        enter(PH_RB_HIGH);
      end
      PH_SP_SETUP: enter(PH_SP_LOW);
      PH_SP_LOW: begin
        m_scl = 1'b1;
        enter(PH_SP_SUSTO);
      end
      PH_SP_SUSTO: begin
        m_sda = 1'b1;
        if (op == OP_RESTART) enter(PH_ST_FREE);
        else wrap_up();
      end
      default: wrap_up();
    endcase
  endfunction

  function automatic result_t step_tick(logic [FUNC_W-1:0] f, logic [15:0] w, logic s);
    result_t r;
    m_done = 1'b0;
    m_sample = s;
    if (m_phase != PH_IDLE) begin
      if (m_ticks < TICK_SAT) m_ticks++;
    end else if (f >= FUNC_GC_RESET && f <= FUNC_WR_CFG) begin
      m_kind = KIND_W'(f - FUNC_GC_RESET);
      m_wval = w;
      m_ack = 4'h0;
      m_byte = 3'd0;
      start_item();
    end
    // zero waits let several bus actions land on one tick
    while (m_phase != PH_IDLE && m_ticks >= wait_ticks()) advance();
    r.scl_release = m_scl;
    r.sda_release = m_sda;
    r.busy_res = (m_phase != PH_IDLE);
    r.done_res = m_done;
    r.read_word = m_rword;
    r.ack_bits = m_ack;
    return r;
  endfunction

  function automatic void reset_mirror();
    reg_dev = RST_DEV_ADDR;
    reg_free = RST_BUS_FREE;
    reg_sthold = RST_START_HOLD;
    reg_dhold = RST_DATA_HOLD;
    reg_dsetup = RST_DATA_SETUP;
    reg_low = RST_CLK_LOW;
    reg_high = RST_CLK_HIGH;
    reg_stop = RST_STOP_SETUP;
    m_phase = PH_IDLE;
    m_ticks = 0;
    m_bit = '0;
    m_byte = '0;
    m_shift = '0;
    m_sda = 1'b1;
    m_scl = 1'b1;
    m_rword = '0;
    m_ack = '0;
    m_kind = KIND_GC;
    m_wval = '0;
    m_done = 1'b0;
    m_sample = 1'b1;
  endfunction

  function automatic logic [REG_W-1:0] short_delay(int unsigned lo);
    return ($urandom_range(0, 3) != 0) ? REG_W'(lo) : REG_W'($urandom_range(lo + 1, 6));
  endfunction

  function automatic bus_timing_t random_timing();
    bus_timing_t t;
    t.dev = ADDR_W'($urandom_range(0, 127));
    t.free = short_delay(1);
    t.sthold = short_delay(1);
    t.dhold = short_delay(0);
    t.dsetup = short_delay(1);
    t.low = short_delay(1);
    t.high = short_delay(1);
    t.stop = short_delay(1);
    return t;
  endfunction

  function automatic bus_timing_t timing_of(logic [1:0] id);
    bus_timing_t t;
    case (id)
      PROF_FAST: t = '{7'd0, 16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1};
      PROF_WIDE: t = '{7'd127, 16'd2, 16'd3, 16'd1, 16'd1, 16'd4, 16'd3, 16'd2};
      default: t = '{7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF};
    endcase
    return t;
  endfunction

  // stop the sender, drain results, then give the sequencer time to settle
  task automatic quiesce();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_res.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_DEV_ADDR:   reg_dev = val[ADDR_W-1:0];
      REG_BUS_FREE:   reg_free = val;
      REG_START_HOLD: reg_sthold = val;
      REG_DATA_HOLD:  reg_dhold = val;
      REG_DATA_SETUP: reg_dsetup = val;
      REG_CLK_LOW:    reg_low = val;
      REG_CLK_HIGH:   reg_high = val;
      default:        reg_stop = val;
    endcase
  endtask

  task automatic program_regs(input bus_timing_t t);
    quiesce();
    write_reg(REG_DEV_ADDR, REG_W'(t.dev));
    write_reg(REG_BUS_FREE, t.free);
    write_reg(REG_START_HOLD, t.sthold);
    write_reg(REG_DATA_HOLD, t.dhold);
    write_reg(REG_DATA_SETUP, t.dsetup);
    write_reg(REG_CLK_LOW, t.low);
    write_reg(REG_CLK_HIGH, t.high);
    write_reg(REG_STOP_SETUP, t.stop);
    n_settings++;
  endtask

  task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [15:0] w, input logic s,
                           input logic typed, input result_t want);
    result_t got;
    int gap;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= {7'd0, s, w};
    do @(posedge clk); while (!in_tready);
    got = step_tick(f, w, s);
    pending_res.push_back(typed ? want : got);
    beats_sent++;
  endtask

  task automatic random_beat();
    logic [FUNC_W-1:0] f;
    if (m_phase == PH_IDLE && $urandom_range(0, 4) != 0) begin
      f = FUNC_GC_RESET + FUNC_W'($urandom_range(0, 3));
    end else if (m_phase == PH_IDLE) begin
      case ($urandom_range(0, 3))
        0: f = FUNC_TICK;
        1: f = FUNC_NONE_A;
        2: f = FUNC_NONE_B;
        default: f = FUNC_NONE_C;
      endcase
    end else begin
      // commands while busy must be dropped
      f = FUNC_W'($urandom_range(0, 7));
    end
    send_beat(f, 16'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic cmp_field(input string nm, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", nm, want, got);
      n_fail++;
    end
  endtask

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 11) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    result_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_res.size() == 0) begin
          $error("result beat with nothing expected: 0x%06h", out_tdata);
          n_fail++;
        end else begin
          e = pending_res.pop_front();
          cmp_field("scl_release", e.scl_release, out_tdata[0]);
          cmp_field("sda_release", e.sda_release, out_tdata[1]);
          cmp_field("busy_res", e.busy_res, out_tdata[2]);
          cmp_field("done_res", e.done_res, out_tdata[3]);
          cmp_field("read_word", e.read_word, out_tdata[19:4]);
          cmp_field("ack_bits", e.ack_bits, out_tdata[23:20]);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("i2c_adc_transaction_master regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    reset_mirror();
    dir_rows.push_back(dir_row_t'{FUNC_TICK, 16'h0000, 1'b1, PROF_KEEP, 1'b1, IDLE_RES,
                                  TAIL_NONE});
    dir_rows.push_back(dir_row_t'{FUNC_NONE_A, 16'hFFFF, 1'b0, PROF_KEEP, 1'b1, IDLE_RES,
                                  TAIL_NONE});
    dir_rows.push_back(dir_row_t'{FUNC_NONE_B, 16'h1234, 1'b1, PROF_KEEP, 1'b1, IDLE_RES,
                                  TAIL_NONE});
    dir_rows.push_back(dir_row_t'{FUNC_NONE_C, 16'h0000, 1'b0, PROF_KEEP, 1'b1, IDLE_RES,
                                  TAIL_NONE});
    // reset timing: the start waits out bus_free, a second command is dropped
    dir_rows.push_back(dir_row_t'{FUNC_GC_RESET, 16'hFFFF, 1'b1, PROF_KEEP, 1'b1, BUSY_RES,
                                  TAIL_NONE});
    dir_rows.push_back(dir_row_t'{FUNC_RD_CFG, 16'h0000, 1'b0, PROF_KEEP, 1'b1, BUSY_RES,
                                  TAIL_HOLD});
    // address 0, overlapping waits, all bytes nacked and read as ones
    dir_rows.push_back(dir_row_t'{FUNC_RD_SAMPLE, 16'h0000, 1'b1, PROF_FAST, 1'b0, '0,
                                  TAIL_HOLD});
    dir_rows.push_back(dir_row_t'{FUNC_TICK, 16'h0000, 1'b0, PROF_KEEP, 1'b0, '0, TAIL_NONE});
    dir_rows.push_back(dir_row_t'{FUNC_WR_CFG, 16'hFFFF, 1'b0, PROF_KEEP, 1'b0, '0, TAIL_HOLD});
    // address 127 with separate low and high waits
    dir_rows.push_back(dir_row_t'{FUNC_WR_CFG, 16'h0000, 1'b1, PROF_WIDE, 1'b0, '0, TAIL_HOLD});
    dir_rows.push_back(dir_row_t'{FUNC_RD_CFG, 16'h0000, 1'b0, PROF_KEEP, 1'b0, '0, TAIL_HOLD});
    dir_rows.push_back(dir_row_t'{FUNC_GC_RESET, 16'h0000, 1'b1, PROF_KEEP, 1'b0, '0,
                                  TAIL_RAND});
    dir_rows.push_back(dir_row_t'{FUNC_RD_SAMPLE, 16'hA5C3, 1'b0, PROF_FAST, 1'b0, '0,
                                  TAIL_RAND});
    dir_rows.push_back(dir_row_t'{FUNC_WR_CFG, 16'h8001, 1'b1, PROF_KEEP, 1'b0, '0, TAIL_RAND});
    dir_rows.push_back(dir_row_t'{FUNC_TICK, 16'h0000, 1'b0, PROF_KEEP, 1'b0, '0, TAIL_NONE});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.prof != PROF_KEEP) program_regs(timing_of(row.prof));
      send_beat(row.func, row.word, row.sda, row.typed, row.want);
      while (row.tail != TAIL_NONE && m_phase != PH_IDLE)
        send_beat(FUNC_TICK, 16'($urandom),
                  (row.tail == TAIL_HOLD) ? row.sda : 1'($urandom_range(0, 1)), 1'b0, '0);
    end

    for (int p = 0; p < PHASES; p++) begin
      program_regs(random_timing());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
          // hold the sender until every result is back
          in_tvalid <= 1'b0;
          do @(posedge clk); while (pending_res.size() != 0);
        end
        random_beat();
      end
    end

    // widest timing with no idling on either side; the start never completes
    program_regs(timing_of(PROF_MAX));
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    for (int n = 0; n < TAIL_ITEMS; n++) random_beat();

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_res.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_res.size() != 0) begin
      $error("%0d results never arrived", pending_res.size());
      n_fail++;
    end
    $display("covered %0d tick beats under %0d register settings, %0d results compared",
             beats_sent, n_settings, results_seen);
    $display("transactions finished: %0d general call, %0d config read, %0d sample read, %0d config write",
             done_by_kind[KIND_GC], done_by_kind[KIND_RD_CFG], done_by_kind[KIND_RD_SAMPLE],
             done_by_kind[KIND_WR_CFG]);
    if (n_fail == 0) begin
      $display("i2c_adc_transaction_master regression: pass");
    end else begin
      $display("i2c_adc_transaction_master regression: fail");
    end
    $finish;
  end

endmodule

>>> i2c_adc_transaction_master.f
+incdir+design
design/i2cadc_pkg.sv
design/i2cadc_cfg.sv
design/i2cadc_core.sv
design/i2cadc_out.sv
design/i2c_adc_transaction_master.sv
sim/tb_i2c_adc_transaction_master.sv
